// ===== hdl/fqp_pkg.sv =====
// Shared types, codes and control/status bundles for the promote-to-front queue.
`default_nettype none

package fqp_pkg;

	// Default queue depth and fixed field widths
	localparam int DEPTH_DEF = 16;
	localparam int KEY_W     = 32;
	localparam int FUNC_W    = 2;
	localparam int STAT_W    = 2;
	localparam int CNT_OUT_W = 5;

	// Operation codes; code 3 is unused and treated as a no-op
	typedef logic [FUNC_W-1:0] func_t;
	localparam func_t FUNC_ENQ     = 2'd0;
	localparam func_t FUNC_DEQ     = 2'd1;
	localparam func_t FUNC_PROMOTE = 2'd2;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic    capture;   // latch the incoming transaction
		logic    enq;       // write key at tail, bump count
		logic    deq_rd;    // read the front entry
		logic    deq_done;  // take front data, advance head, drop count
		logic    idx_clr;   // start search at the front
		logic    rd_idx;    // read entry at search index
		logic    idx_inc;   // advance search index
		logic    sh_rd;     // read entry just ahead of index
		logic    sh_wr;     // write that entry at index, step index down
		logic    put;       // write key at the front
		logic    set_res;   // record status with zero key
		status_t res_code;  // status to record
		logic    load_out;  // move the result into the output register
	} fqp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		func_t func;
		logic  empty;
		logic  full;
		logic  hit;
		logic  idx_zero;
		logic  idx_last;
		logic  idx_one;
		logic  out_free;
	} fqp_sts_t;

endpackage

`default_nettype wire

// ===== hdl/fqp_cmd_if.sv =====
// Input channel: operation and key with valid/ready handshake.
`default_nettype none

interface fqp_cmd_if import fqp_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [FUNC_W-1:0]       func;
	logic signed [KEY_W-1:0] key;

	modport source (output valid, output func, output key, input ready);
	modport sink   (input valid, input func, input key, output ready);
endinterface

`default_nettype wire

// ===== hdl/fqp_res_if.sv =====
// Result channel: status, dequeued key and entry count with valid/ready handshake.
`default_nettype none

interface fqp_res_if import fqp_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [STAT_W-1:0]       status;
	logic signed [KEY_W-1:0] key_out;
	logic [CNT_OUT_W-1:0]    count;

	modport source (output valid, output status, output key_out, output count, input ready);
	modport sink   (input valid, input status, input key_out, input count, output ready);
endinterface

`default_nettype wire

// ===== hdl/fqp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fqp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/fqp_dpath.sv =====
// Datapath: ring-buffer storage, pointers, search index and result registers.
`default_nettype none

module fqp_dpath import fqp_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	localparam int AW   = $clog2(DEPTH),
	localparam int CW   = $clog2(DEPTH + 1)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire fqp_cmd_t                cmd,
	output fqp_sts_t                     sts,
	input  wire logic [FUNC_W-1:0]       in_func,
	input  wire logic signed [KEY_W-1:0] in_key,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [STAT_W-1:0]            out_status,
	output logic signed [KEY_W-1:0]      out_key,
	output logic [CNT_OUT_W-1:0]         out_count
);

	logic [AW-1:0]    head_q;
	logic [CW-1:0]    count_q;
	logic [AW-1:0]    idx_q;
	func_t            func_q;
	logic [KEY_W-1:0] key_q;
	status_t          res_status_q;
	logic [KEY_W-1:0] res_key_q;
	logic             out_valid_q;
	logic [STAT_W-1:0]    out_status_q;
	logic [KEY_W-1:0]     out_key_q;
	logic [CNT_OUT_W-1:0] out_count_q;

	logic [CW-1:0]    off;
	logic [CW:0]      addr_sum;
	logic [AW-1:0]    addr;
	logic             ram_we;
	logic             ram_re;
	logic [KEY_W-1:0] ram_wdata;
	logic [KEY_W-1:0] ram_rdata;

	// Select the offset from the head for this cycle's memory access
	always_comb begin
		off = '0;
		if (cmd.enq) begin
			off = count_q;
		end else if (cmd.rd_idx || cmd.sh_wr) begin
			off = CW'(idx_q);
		end else if (cmd.sh_rd) begin
			off = CW'(idx_q) - CW'(1);
		end
	end

	// Wrap head plus offset around the ring
	always_comb begin
		addr_sum = (CW+1)'(head_q) + (CW+1)'(off);
		if (addr_sum >= (CW+1)'(DEPTH)) begin
			addr_sum = addr_sum - (CW+1)'(DEPTH);
		end
		addr = AW'(addr_sum);
	end

	assign ram_we    = cmd.enq || cmd.sh_wr || cmd.put;
	assign ram_re    = cmd.deq_rd || cmd.rd_idx || cmd.sh_rd;
	assign ram_wdata = cmd.sh_wr ? ram_rdata : key_q;

	fqp_ram #(
		.WIDTH (KEY_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (addr),
		.rdata (ram_rdata)
	);

	// Latch the accepted transaction
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func_t'(in_func);
			key_q  <= in_key;
		end
	end

	// Advance head, count and search index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.enq) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.deq_done) begin
				count_q <= count_q - CW'(1);
				head_q  <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
			end
			if (cmd.put) begin
				idx_q <= '0;
			end else if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + AW'(1);
			end else if (cmd.sh_wr) begin
				idx_q <= idx_q - AW'(1);
			end
		end
	end

	// Record the pending result
	always_ff @(posedge clk) begin
		if (cmd.set_res) begin
			res_status_q <= cmd.res_code;
			res_key_q    <= '0;
		end else if (cmd.deq_done) begin
			res_status_q <= STAT_OK;
			res_key_q    <= ram_rdata;
		end
	end

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_key_q    <= res_key_q;
			out_count_q  <= CNT_OUT_W'(count_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_key    = out_key_q;
	assign out_count  = out_count_q;

	// Report status to the controller
	always_comb begin
		sts.func     = func_q;
		sts.empty    = (count_q == '0);
		sts.full     = (count_q == CW'(DEPTH));
		sts.hit      = (ram_rdata == key_q);
		sts.idx_zero = (idx_q == '0);
		sts.idx_last = ((CW'(idx_q) + CW'(1)) == count_q);
		sts.idx_one  = (idx_q == AW'(1));
		sts.out_free = !out_valid_q || out_ready;
	end

endmodule

`default_nettype wire

// ===== hdl/fqp_ctrl.sv =====
// Controller: sequences each operation over the datapath one step per state.
`default_nettype none

module fqp_ctrl import fqp_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire fqp_sts_t sts,
	output fqp_cmd_t      cmd
);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_DISP = 9'b000000010,
		ST_DEQ  = 9'b000000100,
		ST_SRD  = 9'b000001000,
		ST_SCHK = 9'b000010000,
		ST_SHRD = 9'b000100000,
		ST_SHWR = 9'b001000000,
		ST_PUT  = 9'b010000000,
		ST_FIN  = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	// Decode state into datapath commands
	always_comb begin
		cmd      = '0;
		cmd.res_code = STAT_OK;
		state_d  = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DISP;
				end
			end
			ST_DISP: begin
				case (sts.func)
					FUNC_ENQ: begin
						cmd.set_res = 1'b1;
						if (sts.full) begin
							cmd.res_code = STAT_FULL;
						end else begin
							cmd.enq = 1'b1;
						end
						state_d = ST_FIN;
					end
					FUNC_DEQ: begin
						if (sts.empty) begin
							cmd.set_res  = 1'b1;
							cmd.res_code = STAT_EMPTY;
							state_d      = ST_FIN;
						end else begin
							cmd.deq_rd = 1'b1;
							state_d    = ST_DEQ;
						end
					end
					FUNC_PROMOTE: begin
						if (sts.empty) begin
							cmd.set_res  = 1'b1;
							cmd.res_code = STAT_EMPTY;
							state_d      = ST_FIN;
						end else begin
							cmd.idx_clr = 1'b1;
							state_d     = ST_SRD;
						end
					end
					default: begin
						cmd.set_res = 1'b1;
						state_d     = ST_FIN;
					end
				endcase
			end
			ST_DEQ: begin
				cmd.deq_done = 1'b1;
				state_d      = ST_FIN;
			end
			ST_SRD: begin
				cmd.rd_idx = 1'b1;
				state_d    = ST_SCHK;
			end
			ST_SCHK: begin
				if (sts.hit) begin
					if (sts.idx_zero) begin
						cmd.set_res = 1'b1;
						state_d     = ST_FIN;
					end else begin
						state_d = ST_SHRD;
					end
				end else if (sts.idx_last) begin
					cmd.set_res  = 1'b1;
					cmd.res_code = STAT_NOT_FOUND;
					state_d      = ST_FIN;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = ST_SRD;
				end
			end
			ST_SHRD: begin
				cmd.sh_rd = 1'b1;
				state_d   = ST_SHWR;
			end
			ST_SHWR: begin
				cmd.sh_wr = 1'b1;
				state_d   = sts.idx_one ? ST_PUT : ST_SHRD;
			end
			ST_PUT: begin
				cmd.put     = 1'b1;
				cmd.set_res = 1'b1;
				state_d     = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/fifo_queue_with_promote_to_front.sv =====
// Top level of the bounded key queue with promote-to-front.
// Usage: the cmd channel carries one operation (enqueue, dequeue, promote) and a
// signed 32-bit key per transaction; the res channel returns one transaction per
// operation with status, dequeued key (zero unless a dequeue succeeds) and the
// entry count after the operation. Entries live in a ring buffer in one RAM.
// The controller handles one operation at a time; cmd.ready is high only while
// it is idle. A dequeue reads the front entry through the registered RAM read
// port. A promote searches from the front, reading each entry (ST_SRD) and then
// comparing it (ST_SCHK); on a match away from the front it shifts the entries
// ahead of the match back by one, reading each (ST_SHRD) and then writing it
// (ST_SHWR), and then writes the key at the front. The result turns valid at the
// same edge at which cmd.ready rises again. The RAM has a single read port, so
// the search and the shift each move through one entry at a time.
// A finished result sits in an output register; while res stalls the block still
// takes a new transaction and works it up to the point where its result is ready,
// then waits. Reset empties the queue (head and count cleared, no RAM clearing)
// and drops any undelivered result.
`default_nettype none

module fifo_queue_with_promote_to_front import fqp_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	fqp_cmd_if.sink   cmd,
	fqp_res_if.source res
);

	fqp_cmd_t ctl_cmd;
	fqp_sts_t dp_sts;

	// Sequence each operation
	fqp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (cmd.ready),
		.sts      (dp_sts),
		.cmd      (ctl_cmd)
	);

	// Hold the queue and the result
	fqp_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (ctl_cmd),
		.sts        (dp_sts),
		.in_func    (cmd.func),
		.in_key     (cmd.key),
		.out_valid  (res.valid),
		.out_ready  (res.ready),
		.out_status (res.status),
		.out_key    (res.key_out),
		.out_count  (res.count)
	);

endmodule

`default_nettype wire

// ===== test/tb_fifo_queue_with_promote_to_front.sv =====
// Self-checking testbench for the promote-to-front key queue: driver, monitor, predictor.
`default_nettype none

module tb_fifo_queue_with_promote_to_front;
	import fqp_pkg::*;

	localparam int QDEPTH      = DEPTH_DEF;
	localparam int RANDOM_OPS  = 1090;
	localparam int DRAIN_EVERY = 250;
	localparam int TAIL_CYCLES = 100;
	localparam int POOL_SIZE   = 8;

	// Unused operation code, the block treats it as a no-op
	localparam func_t FUNC_NOP = 2'd3;

	typedef struct {
		func_t                   func;
		logic signed [KEY_W-1:0] key;
		int unsigned             gap;
		bit                      drain;
	} queue_op_t;

	typedef struct {
		status_t                 status;
		logic signed [KEY_W-1:0] key_out;
		logic [CNT_OUT_W-1:0]    count;
	} queue_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b1;

	fqp_cmd_if cmd ();
	fqp_res_if res ();

	fifo_queue_with_promote_to_front #(
		.DEPTH(QDEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.res(res)
	);

	// Predictor state: front of the queue is index 0
	logic signed [KEY_W-1:0] held_keys[$];
	queue_result_t           expected_results[$];
	queue_op_t               pending_ops[$];

	int          mismatches = 0;
	int          in_flight  = 0;
	int unsigned ready_hold = 0;
	bit          sink_burst = 1'b0;

	// Stimulus generator state
	bit                      src_burst = 1'b0;
	int                      gen_fill  = 0;
	logic signed [KEY_W-1:0] key_pool[POOL_SIZE];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one operation to the predicted queue and return its result
	function automatic queue_result_t apply_queue_op(func_t op, logic signed [KEY_W-1:0] k);
		queue_result_t r;
		int            hit;
		r.status  = STAT_OK;
		r.key_out = '0;
		case (op)
			FUNC_ENQ: begin
				if (held_keys.size() >= QDEPTH)
					r.status = STAT_FULL;
				else
					held_keys.push_back(k);
			end
			FUNC_DEQ: begin
				if (held_keys.size() == 0)
					r.status = STAT_EMPTY;
				else
					r.key_out = held_keys.pop_front();
			end
			FUNC_PROMOTE: begin
				if (held_keys.size() == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					hit = -1;
					for (int i = 0; i < held_keys.size() && hit < 0; i++)
						if (held_keys[i] == k)
							hit = i;
					if (hit < 0) begin
						r.status = STAT_NOT_FOUND;
					end else begin
						held_keys.delete(hit);
						held_keys.push_front(k);
					end
				end
			end
			default: ;
		endcase
		r.count = CNT_OUT_W'(held_keys.size());
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	// Queue one operation, with a random lead gap unless in a burst stretch
	task automatic add_op(input func_t f, input logic signed [KEY_W-1:0] k, input bit drain);
		queue_op_t op;
		if ($urandom_range(0, 39) == 0)
			src_burst = !src_burst;
		op.func  = f;
		op.key   = k;
		op.gap   = src_burst ? 0 : $urandom_range(0, 7);
		op.drain = drain;
		pending_ops.push_back(op);
		if (f == FUNC_ENQ && gen_fill < QDEPTH)
			gen_fill++;
		else if (f == FUNC_DEQ && gen_fill > 0)
			gen_fill--;
	endtask

	// Mostly pool keys so that promotes hit and duplicates occur
	function automatic logic signed [KEY_W-1:0] pick_key(int pool_pct);
		if ($urandom_range(0, 99) < pool_pct)
			return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		return $urandom;
	endfunction

	// Drive command transactions from the pending queue and predict on acceptance
	always @(posedge clk or negedge arst_n) begin : drive_cmd
		queue_op_t op;
		bit        send_now;
		if (!arst_n) begin
			cmd.valid <= 1'b0;
			cmd.func  <= FUNC_ENQ;
			cmd.key   <= '0;
			in_flight = 0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				expected_results.push_back(apply_queue_op(cmd.func, cmd.key));
				in_flight++;
			end
			if (res.valid && res.ready)
				in_flight--;
			if (!cmd.valid || cmd.ready) begin
				send_now = 1'b0;
				if (pending_ops.size() != 0) begin
					if (pending_ops[0].gap != 0)
						pending_ops[0].gap = pending_ops[0].gap - 1;
					else if (!pending_ops[0].drain || in_flight == 0)
						send_now = 1'b1;
				end
				if (send_now) begin
					op = pending_ops.pop_front();
					cmd.func <= op.func;
					cmd.key  <= op.key;
				end
				cmd.valid <= send_now;
			end
		end
	end

	// Accept result transactions with random stalls and compare against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : check_results
		queue_result_t want;
		if (!arst_n) begin
			res.ready <= 1'b0;
			ready_hold = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result status %0d key %0d count %0d",
						res.status, res.key_out, res.count));
				end else begin
					want = expected_results.pop_front();
					if (res.status !== want.status)
						report_mismatch($sformatf("status got %0d expected %0d",
							res.status, want.status));
					if (res.key_out !== want.key_out)
						report_mismatch($sformatf("key_out got %0d expected %0d",
							res.key_out, want.key_out));
					if (res.count !== want.count)
						report_mismatch($sformatf("count got %0d expected %0d",
							res.count, want.count));
				end
				if ($urandom_range(0, 63) == 0)
					sink_burst = !sink_burst;
				ready_hold = sink_burst ? 0 : $urandom_range(0, 7);
			end
			if (ready_hold != 0) begin
				ready_hold--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	// Reset once at the start
	initial begin
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Hard stop if the run hangs
	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Build the stimulus, then wait for the queue to drain and judge the run
	initial begin : run_stimulus
		logic signed [KEY_W-1:0] last_key;
		int                      counted;
		int                      phase;
		int                      pick;
		func_t                   f;

		key_pool[0] = 32'sh8000_0000;
		key_pool[1] = 32'sh7fff_ffff;
		key_pool[2] = '0;
		key_pool[3] = -32'sd1;
		key_pool[4] = 32'sd1;
		for (int i = 5; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;

		// Directed: empty cases, extremes, promote positions, full queue
		add_op(FUNC_DEQ, 32'sd0, 1'b0);
		add_op(FUNC_PROMOTE, 32'sd5, 1'b0);
		add_op(FUNC_NOP, 32'sh7fff_ffff, 1'b0);
		add_op(FUNC_ENQ, 32'sh8000_0000, 1'b0);
		add_op(FUNC_ENQ, 32'sh7fff_ffff, 1'b0);
		add_op(FUNC_ENQ, 32'sd0, 1'b0);
		add_op(FUNC_ENQ, -32'sd1, 1'b0);
		add_op(FUNC_PROMOTE, 32'sh7fff_ffff, 1'b0);
		add_op(FUNC_PROMOTE, 32'sh7fff_ffff, 1'b0);
		add_op(FUNC_PROMOTE, 32'sd12345, 1'b0);
		add_op(FUNC_PROMOTE, -32'sd1, 1'b0);
		add_op(FUNC_DEQ, 32'sd0, 1'b0);
		last_key = '0;
		while (gen_fill < QDEPTH) begin
			last_key = $urandom;
			add_op(FUNC_ENQ, last_key, 1'b0);
		end
		add_op(FUNC_ENQ, 32'sh5a5a_a5a5, 1'b0);
		add_op(FUNC_PROMOTE, last_key, 1'b0);
		add_op(FUNC_DEQ, 32'sd0, 1'b0);

		// Random: phases that fill, drain or mix, with no-op noise
		counted = 0;
		phase   = 0;
		while (counted < RANDOM_OPS) begin
			if ($urandom_range(0, 31) == 0) begin
				add_op(FUNC_NOP, $urandom, 1'b0);
			end else begin
				if (gen_fill >= QDEPTH && $urandom_range(0, 3) == 0)
					phase = 1;
				else if (gen_fill == 0 && $urandom_range(0, 3) == 0)
					phase = 0;
				else if ($urandom_range(0, 40) == 0)
					phase = $urandom_range(0, 2);
				pick = $urandom_range(0, 99);
				case (phase)
					0:       f = (pick < 70) ? FUNC_ENQ : (pick < 80) ? FUNC_DEQ : FUNC_PROMOTE;
					1:       f = (pick < 20) ? FUNC_ENQ : (pick < 80) ? FUNC_DEQ : FUNC_PROMOTE;
					default: f = (pick < 35) ? FUNC_ENQ : (pick < 65) ? FUNC_DEQ : FUNC_PROMOTE;
				endcase
				add_op(f, pick_key((f == FUNC_PROMOTE) ? 85 : 75), (counted % DRAIN_EVERY) == 0);
				counted++;
			end
		end

		// Wait until everything is sent and answered, then let the tail run out
		@(negedge clk);
		while (pending_ops.size() != 0 || cmd.valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
